// ===== rtl/ihm_pkg.sv =====
// Package for the interval halving minimizer: widths, reset values, register
// indexes, control word types and the microcode program of the sequencer.
// Has no dependencies; every other file of the block imports it.
package ihm_pkg;

    localparam int unsigned XW    = 32;  // Q16.16 point width
    localparam int unsigned FW    = 64;  // Q32.32 function value width
    localparam int unsigned MW    = 33;  // multiplier operand width
    localparam int unsigned PRW   = 66;  // multiplier product width
    localparam int unsigned ACCW  = 96;  // accumulator width, units of 2^-48
    localparam int unsigned TOLW  = 31;
    localparam int unsigned RW    = 6;   // round counter width
    localparam int unsigned CW    = 8;   // evaluation counter width
    localparam int unsigned STEPW = 5;   // microcode address width
    localparam int unsigned CIW   = 3;   // configuration index width
    localparam int unsigned CDW   = 32;  // configuration data width

    localparam logic [XW-1:0]   RST_COEF_SQUARE   = 32'd16777216;
    localparam logic [XW-1:0]   RST_COEF_LINEAR   = 32'd15787622;
    localparam logic [XW-1:0]   RST_COEF_CONSTANT = 32'd4194304;
    localparam logic [TOLW-1:0] RST_TOLERANCE     = 31'd66;
    localparam logic [RW-1:0]   RST_ITER_LIMIT    = 6'd40;

    localparam logic [CIW-1:0] CFG_COEF_SQUARE   = 3'd0;
    localparam logic [CIW-1:0] CFG_COEF_LINEAR   = 3'd1;
    localparam logic [CIW-1:0] CFG_COEF_CONSTANT = 3'd2;
    localparam logic [CIW-1:0] CFG_TOLERANCE     = 3'd3;
    localparam logic [CIW-1:0] CFG_ITER_LIMIT    = 3'd4;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_XX, MUL_C1X, MUL_C2LO, MUL_C2HI
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_C0, ACC_ADD0, ACC_ADD16, ACC_ADD32
    } t_acc_op;

    typedef struct packed {
        t_mul_sel mul;
        t_acc_op  acc;
        logic     sq_ld;
    } t_eval_ctl;

    typedef enum logic [1:0] {X_HOLD, X_ONE, X_TWO, X_CTR} t_xsel;
    typedef enum logic [1:0] {F_NONE, F_ONE, F_TWO, F_CTR} t_fsel;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_DECIDE, OP_SETHIT, OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT, C_WAIT_IN, C_TOL, C_NOLIMIT, C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_eval_ctl        ev;
        t_xsel            xsel;
        t_fsel            fsel;
        t_op              op;
        t_cond            cond;
        logic [STEPW-1:0] target;
    } t_cword;

    localparam t_eval_ctl EV_NOP = '{mul: MUL_NONE, acc: ACC_HOLD, sq_ld: 1'b0};

    // Program addresses.
    localparam logic [STEPW-1:0] ST_IDLE  = 5'd0;
    localparam logic [STEPW-1:0] ST_ROUND = 5'd2;
    localparam logic [STEPW-1:0] ST_EV1   = 5'd3;
    localparam logic [STEPW-1:0] ST_EV2   = 5'd9;
    localparam logic [STEPW-1:0] ST_EV3   = 5'd15;
    localparam logic [STEPW-1:0] ST_FINAL = 5'd25;
    localparam logic [STEPW-1:0] ST_EV4   = 5'd26;
    localparam logic [STEPW-1:0] ST_EMIT  = 5'd31;

    // One evaluation of the quadratic takes five steps on the shared multiplier.
    function automatic t_eval_ctl ev_step(input logic [2:0] k);
        t_eval_ctl c;
        c = EV_NOP;
        case (k)
            3'd0: c = '{mul: MUL_XX,   acc: ACC_C0,    sq_ld: 1'b0};
            3'd1: c = '{mul: MUL_C1X,  acc: ACC_HOLD,  sq_ld: 1'b1};
            3'd2: c = '{mul: MUL_C2LO, acc: ACC_ADD16, sq_ld: 1'b0};
            3'd3: c = '{mul: MUL_C2HI, acc: ACC_ADD0,  sq_ld: 1'b0};
            3'd4: c = '{mul: MUL_NONE, acc: ACC_ADD32, sq_ld: 1'b0};
            default: c = EV_NOP;
        endcase
        return c;
    endfunction

    function automatic t_cword uc_rom(input logic [STEPW-1:0] step);
        t_cword w;
        w = '{ev: EV_NOP, xsel: X_HOLD, fsel: F_NONE, op: OP_NONE,
              cond: C_NEXT, target: ST_IDLE};
        case (step)
            5'd0: begin
                w.op = OP_LOAD; w.cond = C_WAIT_IN; w.target = ST_IDLE;
            end
            5'd1: w.op = OP_INIT;
            5'd2: w.xsel = X_ONE;
            5'd3, 5'd4, 5'd5, 5'd6, 5'd7: w.ev = ev_step(3'(step - ST_EV1));
            5'd8: begin
                w.fsel = F_ONE; w.xsel = X_TWO;
            end
            5'd9, 5'd10, 5'd11, 5'd12, 5'd13: w.ev = ev_step(3'(step - ST_EV2));
            5'd14: begin
                w.fsel = F_TWO; w.xsel = X_CTR;
            end
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19: w.ev = ev_step(3'(step - ST_EV3));
            5'd20: w.fsel = F_CTR;
            5'd21: w.op = OP_DECIDE;
            5'd22: begin
                w.cond = C_TOL; w.target = ST_FINAL;
            end
            5'd23: begin
                w.cond = C_NOLIMIT; w.target = ST_ROUND;
            end
            5'd24: w.op = OP_SETHIT;
            5'd25: w.xsel = X_CTR;
            5'd26, 5'd27, 5'd28, 5'd29, 5'd30: w.ev = ev_step(3'(step - ST_EV4));
            5'd31: begin
                w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = ST_EMIT;
            end
            default: w.op = OP_NONE;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ihm_if.sv =====
// Valid/ready channel interfaces of the interval halving minimizer: one for
// search requests and one for results. Depends on ihm_pkg for field widths.
interface ihm_in_if import ihm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] start_low;
    logic signed [XW-1:0] start_high;

    modport source (output valid, output start_low, output start_high, input ready);
    modport sink   (input valid, input start_low, input start_high, output ready);
endinterface

interface ihm_out_if import ihm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] final_low;
    logic signed [XW-1:0] final_high;
    logic signed [XW-1:0] best_point;
    logic signed [FW-1:0] best_value;
    logic [RW-1:0]        rounds_done;
    logic [CW-1:0]        evaluations;
    logic                 limit_hit;

    modport source (output valid, output final_low, output final_high,
                    output best_point, output best_value, output rounds_done,
                    output evaluations, output limit_hit, input ready);
    modport sink   (input valid, input final_low, input final_high,
                    input best_point, input best_value, input rounds_done,
                    input evaluations, input limit_hit, output ready);
endinterface

// ===== rtl/interval_halving_minimizer.sv =====
// Top level of the interval halving minimizer: microcoded sequencer, search
// registers, configuration registers and result register. Uses ihm_pkg,
// the channel interfaces of ihm_if and the evaluation datapath ihm_quad.

// The block takes one search request (start_low, start_high, signed Q16.16;
// the bounds are swapped if given in reverse) and finds the minimum of
// coef_square*x^2 + coef_linear*x + coef_constant by three-point interval
// halving. Each round evaluates f at the two quarter points and the center
// and keeps the left half if f is lower at the first quarter point than at
// the center, else the right half if it is lower at the second, else the
// middle half. The search stops when the width falls below the tolerance or
// after iteration_limit rounds (a limit of zero counts as one; the default
// is 40), in which case limit_hit is set. f is evaluated exactly and floored
// to signed Q32.32 with saturation. Every evaluation takes four products on
// a single shared 33x33 multiplier and the microcode spends 22 steps on each
// round. Requests are taken one at a time; the result sits in an output
// register, so the next request is accepted while the previous result still
// waits to be taken. Configuration registers are written through a simple
// write port and must only change while the block is idle.
module interval_halving_minimizer import ihm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [CIW-1:0] i_cfg_idx,
    input  logic [CDW-1:0] i_cfg_data,
    ihm_in_if.sink         i_req,
    ihm_out_if.source      o_res
);

    // Configuration registers.
    logic signed [XW-1:0] r_coef_square;
    logic signed [XW-1:0] r_coef_linear;
    logic signed [XW-1:0] r_coef_constant;
    logic [TOLW-1:0]      r_tolerance;
    logic [RW-1:0]        r_iter_limit;

    // Sequencer.
    logic [STEPW-1:0] r_step;
    logic [STEPW-1:0] n_step;
    t_cword           w_cw;
    logic             w_jump;
    logic             w_accept;

    // Search state.
    logic signed [XW-1:0] r_a;
    logic signed [XW-1:0] r_b;
    logic signed [XW-1:0] r_xc;
    logic signed [XW-1:0] r_x;
    logic signed [FW-1:0] r_f1;
    logic signed [FW-1:0] r_f2;
    logic signed [FW-1:0] r_fc;
    logic [RW-1:0]        r_rounds;
    logic [CW-1:0]        r_calls;
    logic                 r_hit;

    // Result register.
    logic                 r_out_valid;
    logic signed [XW-1:0] r_out_low;
    logic signed [XW-1:0] r_out_high;
    logic signed [XW-1:0] r_out_point;
    logic signed [FW-1:0] r_out_value;
    logic [RW-1:0]        r_out_rounds;
    logic [CW-1:0]        r_out_calls;
    logic                 r_out_hit;

    logic [XW:0]          w_len;
    logic [XW-2:0]        w_q;
    logic signed [XW-1:0] w_x1;
    logic signed [XW-1:0] w_x2;
    logic signed [XW-1:0] w_xmid;
    logic [RW-1:0]        w_limit;
    logic                 w_tol_hit;
    logic                 w_lim_ok;
    logic                 w_lt1;
    logic                 w_lt2;
    logic signed [FW-1:0] w_f;
    logic                 w_emit;

    assign w_cw        = uc_rom(r_step);
    assign i_req.ready = (w_cw.cond == C_WAIT_IN);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_emit      = (w_cw.op == OP_EMIT) && !r_out_valid;

    // Interval geometry. The width is nonnegative and may need 33 bits; the
    // quarter and center points always land inside the interval, so a
    // 32-bit wrapping add gives them exactly.
    assign w_len  = {r_b[XW-1], r_b} - {r_a[XW-1], r_a};
    assign w_q    = w_len[XW:2];
    assign w_x1   = r_a + {1'b0, w_q};
    assign w_x2   = r_b - {1'b0, w_q};
    assign w_xmid = r_a + w_len[XW:1];

    assign w_limit   = (r_iter_limit == '0) ? RW'(1) : r_iter_limit;
    assign w_tol_hit = w_len < {2'b00, r_tolerance};
    assign w_lim_ok  = r_rounds < w_limit;
    assign w_lt1     = r_f1 < r_fc;
    assign w_lt2     = r_f2 < r_fc;

    ihm_quad u_quad (
        .i_clk           (i_clk),
        .i_ctl           (w_cw.ev),
        .i_coef_square   (r_coef_square),
        .i_coef_linear   (r_coef_linear),
        .i_coef_constant (r_coef_constant),
        .i_x             (r_x),
        .o_f             (w_f)
    );

    // Conditional jumps of the program. The wait conditions jump to their
    // own step, which holds the sequencer until the handshake allows it on.
    always_comb begin
        case (w_cw.cond)
            C_WAIT_IN:  w_jump = !w_accept;
            C_TOL:      w_jump = w_tol_hit;
            C_NOLIMIT:  w_jump = w_lim_ok;
            C_OUT_BUSY: w_jump = r_out_valid;
            default:    w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_cw.target : r_step + 1'b1;
    end

    // Control state: sequencer, result handshake and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step          <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_coef_square   <= RST_COEF_SQUARE;
            r_coef_linear   <= RST_COEF_LINEAR;
            r_coef_constant <= RST_COEF_CONSTANT;
            r_tolerance     <= RST_TOLERANCE;
            r_iter_limit    <= RST_ITER_LIMIT;
        end else begin
            r_step <= n_step;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COEF_SQUARE:   r_coef_square   <= i_cfg_data;
                    CFG_COEF_LINEAR:   r_coef_linear   <= i_cfg_data;
                    CFG_COEF_CONSTANT: r_coef_constant <= i_cfg_data;
                    CFG_TOLERANCE:     r_tolerance     <= i_cfg_data[TOLW-1:0];
                    CFG_ITER_LIMIT:    r_iter_limit    <= i_cfg_data[RW-1:0];
                    default:           r_iter_limit    <= r_iter_limit;
                endcase
            end
        end
    end

    // Search datapath driven by the current control word.
    always_ff @(posedge i_clk) begin
        case (w_cw.op)
            OP_LOAD: begin
                if (w_accept) begin
                    if (i_req.start_low > i_req.start_high) begin
                        r_a <= i_req.start_high;
                        r_b <= i_req.start_low;
                    end else begin
                        r_a <= i_req.start_low;
                        r_b <= i_req.start_high;
                    end
                    // The count starts at one for an initial evaluation at the center;
                    // that evaluation is not performed, it is only counted.
                    r_rounds <= '0;
                    r_calls  <= CW'(1);
                    r_hit    <= 1'b0;
                end
            end
            OP_INIT: r_xc <= w_xmid;
            OP_DECIDE: begin
                if (w_lt1) begin
                    r_b  <= r_xc;
                    r_xc <= w_x1;
                end else if (w_lt2) begin
                    r_a  <= r_xc;
                    r_xc <= w_x2;
                end else begin
                    r_a <= w_x1;
                    r_b <= w_x2;
                end
                r_rounds <= r_rounds + 1'b1;
                r_calls  <= r_calls + CW'(3);
            end
            OP_SETHIT: r_hit <= 1'b1;
            OP_EMIT: begin
                if (w_emit) begin
                    r_out_low    <= r_a;
                    r_out_high   <= r_b;
                    r_out_point  <= r_xc;
                    r_out_value  <= w_f;
                    r_out_rounds <= r_rounds;
                    r_out_calls  <= r_calls + 1'b1;
                    r_out_hit    <= r_hit;
                end
            end
            default: r_hit <= r_hit;
        endcase

        case (w_cw.xsel)
            X_ONE:   r_x <= w_x1;
            X_TWO:   r_x <= w_x2;
            X_CTR:   r_x <= r_xc;
            default: r_x <= r_x;
        endcase

        case (w_cw.fsel)
            F_ONE:   r_f1 <= w_f;
            F_TWO:   r_f2 <= w_f;
            F_CTR:   r_fc <= w_f;
            default: r_fc <= r_fc;
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.final_low   = r_out_low;
    assign o_res.final_high  = r_out_high;
    assign o_res.best_point  = r_out_point;
    assign o_res.best_value  = r_out_value;
    assign o_res.rounds_done = r_out_rounds;
    assign o_res.evaluations = r_out_calls;
    assign o_res.limit_hit   = r_out_hit;

endmodule

// ===== rtl/ihm_quad.sv =====
// Quadratic evaluation datapath: one shared 33x33 multiplier, a product
// register, a square register and a 96-bit accumulator. Depends on ihm_pkg.
module ihm_quad import ihm_pkg::*; (
    input  logic                 i_clk,
    input  t_eval_ctl            i_ctl,
    input  logic signed [XW-1:0] i_coef_square,
    input  logic signed [XW-1:0] i_coef_linear,
    input  logic signed [XW-1:0] i_coef_constant,
    input  logic signed [XW-1:0] i_x,
    output logic signed [FW-1:0] o_f
);

    logic signed [MW-1:0]   w_ma;
    logic signed [MW-1:0]   w_mb;
    logic signed [PRW-1:0]  w_mp;
    logic signed [PRW-1:0]  r_prod;
    logic [FW-1:0]          r_sq;
    logic signed [ACCW-1:0] r_acc;
    logic signed [ACCW-1:0] n_acc;
    logic signed [ACCW-1:0] w_pext;
    logic [16:0]            w_top;

    always_comb begin
        case (i_ctl.mul)
            MUL_XX: begin
                w_ma = {i_x[XW-1], i_x};
                w_mb = {i_x[XW-1], i_x};
            end
            MUL_C1X: begin
                w_ma = {i_coef_linear[XW-1], i_coef_linear};
                w_mb = {i_x[XW-1], i_x};
            end
            MUL_C2LO: begin
                w_ma = {i_coef_square[XW-1], i_coef_square};
                w_mb = {1'b0, r_sq[XW-1:0]};
            end
            MUL_C2HI: begin
                w_ma = {i_coef_square[XW-1], i_coef_square};
                w_mb = {1'b0, r_sq[FW-1:XW]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp   = w_ma * w_mb;
    assign w_pext = {{(ACCW-PRW){r_prod[PRW-1]}}, r_prod};

    // The accumulator works in units of 2^-48: the constant term enters
    // shifted by 32, the linear product by 16 and the square term in two
    // halves at 0 and 32.
    always_comb begin
        case (i_ctl.acc)
            ACC_C0:    n_acc = {{(ACCW-64){i_coef_constant[XW-1]}}, i_coef_constant, 32'd0};
            ACC_ADD0:  n_acc = r_acc + w_pext;
            ACC_ADD16: n_acc = r_acc + (w_pext <<< 16);
            ACC_ADD32: n_acc = r_acc + (w_pext <<< 32);
            default:   n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul != MUL_NONE) begin
            r_prod <= w_mp;
        end
        if (i_ctl.sq_ld) begin
            r_sq <= r_prod[FW-1:0];
        end
        r_acc <= n_acc;
    end

    // Floor to Q32.32 by dropping 16 bits, then saturate to 64 bits.
    assign w_top = r_acc[ACCW-1:ACCW-17];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_f = r_acc[FW+15:16];
        end else if (r_acc[ACCW-1]) begin
            o_f = {1'b1, {(FW-1){1'b0}}};
        end else begin
            o_f = {1'b0, {(FW-1){1'b1}}};
        end
    end

endmodule
